/* design/prps_pkg.sv */
// Shared types and constants for the punch record parser and stroke splitter.
// Holds result kind codes, byte values and the controller/datapath interface structs.
// No dependencies.
package prps_pkg;

    localparam int KIND_W = 3;
    localparam int WORD_W = 32;
    localparam int PPS_W  = 5;

    // Result kind codes.
    localparam logic [KIND_W-1:0] KIND_STROKE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_END     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OFFLINE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FAULT   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_BEGIN   = 3'd6;

    // Request opcodes.
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_BEGIN = 1'b1;

    // Byte values of interest.
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_PLUS = 8'h2B;

    // Pin bytes per record before the closing byte.
    localparam logic [2:0] REC_PIN_BYTES = 3'd4;

    // Reset value of the pins-per-stroke register.
    localparam logic [PPS_W-1:0] PPS_RESET = 5'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // an input request is taken this cycle
        logic scan_step;  // scan one pin bit this cycle
        logic ack_load;   // load the record ack into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic start_scan; // the offered request closes a valid pin record
        logic scan_last;  // the bit being scanned is the final one
    } t_status;

endpackage

/* design/prps_ctrl.sv */
// Controller state machine for the punch record parser and stroke splitter.
// Sequences request intake, the bit scan and the record ack; depends on prps_pkg.
module prps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  prps_pkg::t_status i_status,
    output prps_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_ACK  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Requests are taken only when idle and the output slot can take a result.
    assign o_in_ready = (r_state == ST_IDLE) && i_status.out_free;

    // Next state and command decode.
    always_comb begin
        n_state          = r_state;
        o_cmd.accept     = 1'b0;
        o_cmd.scan_step  = 1'b0;
        o_cmd.ack_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_in_valid && o_in_ready;
                if (o_cmd.accept && i_status.start_scan) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = i_status.out_free;
                if (i_status.out_free && i_status.scan_last) begin
                    n_state = ST_ACK;
                end
            end
            ST_ACK: begin
                o_cmd.ack_load = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/prps_datapath.sv */
// Datapath for the punch record parser and stroke splitter: record gathering,
// the pin-word bit scanner and the output register. Depends on prps_pkg.
module prps_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_opcode,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_online_level,
    input  logic                             i_fault_level,
    input  logic                             i_cfg_valid,
    input  logic [prps_pkg::PPS_W-1:0]       i_cfg_data,
    input  prps_pkg::t_cmd                   i_cmd,
    output prps_pkg::t_status                o_status,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [prps_pkg::KIND_W-1:0]      o_out_kind,
    output logic [prps_pkg::WORD_W-1:0]      o_out_word,
    output logic                             o_out_last
);

    localparam int WORD_W = prps_pkg::WORD_W;
    localparam int PPS_W  = prps_pkg::PPS_W;

    // Control state.
    logic                       r_punch_active;
    logic                       r_record_started;
    logic [2:0]                 r_byte_count;
    logic                       r_out_valid;
    logic [PPS_W-1:0]           r_pps;

    // Payload state.
    logic [7:0]                 r_record_bytes [4];
    logic [WORD_W-1:0]          r_word;
    logic [WORD_W-1:0]          r_sel;
    logic [WORD_W-1:0]          r_acc;
    logic [PPS_W-1:0]           r_count;
    logic [prps_pkg::KIND_W-1:0] r_out_kind;
    logic [WORD_W-1:0]          r_out_word;
    logic                       r_out_last;

    // Request decode results.
    logic                        d_emit;
    logic [prps_pkg::KIND_W-1:0] d_kind;
    logic                        d_scan;
    logic                        d_store;
    logic                        d_clear;
    logic                        n_punch_active;
    logic                        d_crlf;
    logic                        d_all_plus;
    logic [WORD_W-1:0]           d_record_word;

    // Scanner signals.
    logic                        s_bit;
    logic [PPS_W:0]              s_count_sum;
    logic                        s_close;
    logic [WORD_W-1:0]           s_take_mask;
    logic [WORD_W-1:0]           s_acc_next;

    logic                        out_free;

    assign out_free = !r_out_valid || i_out_ready;

    assign d_crlf = (i_data_byte == prps_pkg::BYTE_CR) || (i_data_byte == prps_pkg::BYTE_LF);
    assign d_all_plus = (i_data_byte == prps_pkg::BYTE_PLUS)
                     && (r_record_bytes[0] == prps_pkg::BYTE_PLUS)
                     && (r_record_bytes[1] == prps_pkg::BYTE_PLUS)
                     && (r_record_bytes[2] == prps_pkg::BYTE_PLUS)
                     && (r_record_bytes[3] == prps_pkg::BYTE_PLUS);
    assign d_record_word = {r_record_bytes[0], r_record_bytes[1],
                            r_record_bytes[2], r_record_bytes[3]};

    // Decode of the offered request against the record state.
    always_comb begin
        d_emit         = 1'b0;
        d_kind         = prps_pkg::KIND_ACK;
        d_scan         = 1'b0;
        d_store        = 1'b0;
        d_clear        = 1'b0;
        n_punch_active = r_punch_active;
        if (i_opcode == prps_pkg::OP_BEGIN) begin
            n_punch_active = 1'b1;
            d_clear        = 1'b1;
            d_emit         = 1'b1;
            d_kind         = prps_pkg::KIND_BEGIN;
        end else if (!r_punch_active) begin
            // Bytes outside punch mode are dropped.
        end else if (!r_record_started && d_crlf) begin
            // Line breaks between records are skipped.
        end else if (r_byte_count < prps_pkg::REC_PIN_BYTES) begin
            d_store = 1'b1;
        end else begin
            d_clear = 1'b1;
            if (d_crlf) begin
                if (!i_online_level) begin
                    d_emit         = 1'b1;
                    d_kind         = prps_pkg::KIND_OFFLINE;
                    n_punch_active = 1'b0;
                end else if (i_fault_level) begin
                    d_emit         = 1'b1;
                    d_kind         = prps_pkg::KIND_FAULT;
                    n_punch_active = 1'b0;
                end else begin
                    d_scan = 1'b1;
                end
            end else if (d_all_plus) begin
                d_emit         = 1'b1;
                d_kind         = prps_pkg::KIND_END;
                n_punch_active = 1'b0;
            end else begin
                d_emit = 1'b1;
                d_kind = prps_pkg::KIND_INVALID;
            end
        end
    end

    // One pin bit per scan step; the final step also takes the paper feed bit.
    assign s_take_mask = r_sel[WORD_W-2] ? (r_sel | {r_sel[WORD_W-2:0], 1'b0}) : r_sel;
    assign s_bit       = |(r_word & r_sel);
    assign s_acc_next  = r_acc | (r_word & s_take_mask);
    assign s_count_sum = {1'b0, r_count} + {{PPS_W{1'b0}}, s_bit};
    assign s_close     = (s_count_sum >= {1'b0, r_pps}) || r_sel[WORD_W-2];

    assign o_status.out_free   = out_free;
    assign o_status.start_scan = d_scan;
    assign o_status.scan_last  = r_sel[WORD_W-2];

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_punch_active   <= 1'b0;
            r_record_started <= 1'b0;
            r_byte_count     <= 3'd0;
            r_out_valid      <= 1'b0;
            r_pps            <= prps_pkg::PPS_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_pps <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_punch_active <= n_punch_active;
                if (d_clear) begin
                    r_record_started <= 1'b0;
                    r_byte_count     <= 3'd0;
                end else if (d_store) begin
                    r_record_started <= 1'b1;
                    r_byte_count     <= r_byte_count + 3'd1;
                end
            end
            if ((i_cmd.accept && d_emit) || (i_cmd.scan_step && s_close) || i_cmd.ack_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Record bytes and scanner registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && d_store) begin
            r_record_bytes[r_byte_count[1:0]] <= i_data_byte;
        end
        if (i_cmd.accept && d_scan) begin
            r_word  <= d_record_word;
            r_sel   <= {{(WORD_W-1){1'b0}}, 1'b1};
            r_acc   <= '0;
            r_count <= '0;
        end else if (i_cmd.scan_step) begin
            r_sel <= {r_sel[WORD_W-2:0], 1'b0};
            if (s_close) begin
                r_acc   <= '0;
                r_count <= '0;
            end else begin
                r_acc   <= s_acc_next;
                r_count <= s_count_sum[PPS_W-1:0];
            end
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && d_emit) begin
            r_out_kind <= d_kind;
            r_out_word <= '0;
            r_out_last <= 1'b1;
        end else if (i_cmd.scan_step && s_close) begin
            r_out_kind <= prps_pkg::KIND_STROKE;
            r_out_word <= s_acc_next;
            r_out_last <= 1'b0;
        end else if (i_cmd.ack_load) begin
            r_out_kind <= prps_pkg::KIND_ACK;
            r_out_word <= '0;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_word  = r_out_word;
    assign o_out_last  = r_out_last;

endmodule

/* design/punch_record_parser_splitter.sv */
// A begin command (tuser = 1) starts punch mode and is answered with a begin ack.
// In punch mode received bytes are gathered into records of four pin bytes and a
// closing byte; a record closed by CR or LF is checked against the online and fault
// levels and then split into strokes, each closing where the set-pin count reaches
// pins_per_stroke, followed by a record ack. A pin record's closing byte is taken,
// then the bit scanner examines one pin bit per cycle over bits 0 to 30 while the
// output can take a result (an output stall holds it), and then the ack is issued.
// tlast marks the final result of each request. The pins_per_stroke register is
// written on the cfg channel.
// Top level; depends on prps_pkg, prps_ctrl and prps_datapath.
module punch_record_parser_splitter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input stream.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,  // data_byte[7:0], online_level[8],
                                                       // fault_level[9], zero fill
    input  logic                        s_axis_tuser,  // opcode[0]
    // Result stream.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [prps_pkg::WORD_W-1:0] m_axis_tdata,  // pin_word[31:0]
    output logic [prps_pkg::KIND_W-1:0] m_axis_tuser,  // kind[2:0]
    output logic                        m_axis_tlast,
    // Configuration write channel.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [prps_pkg::PPS_W-1:0]  i_cfg_data
);

    prps_pkg::t_cmd    cmd;
    prps_pkg::t_status status;

    // Register writes are always taken.
    assign o_cfg_ready = 1'b1;

    prps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    prps_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_opcode       (s_axis_tuser),
        .i_data_byte    (s_axis_tdata[7:0]),
        .i_online_level (s_axis_tdata[8]),
        .i_fault_level  (s_axis_tdata[9]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_kind     (m_axis_tuser),
        .o_out_word     (m_axis_tdata),
        .o_out_last     (m_axis_tlast)
    );

endmodule

/* bench/punch_record_parser_splitter_tb.sv */
// Self-checking testbench for punch_record_parser_splitter: drives byte and begin requests,
// predicts every result from its own model of the record parser and stroke splitter.
// Depends on prps_pkg and the punch_record_parser_splitter RTL.
module punch_record_parser_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KIND_W = prps_pkg::KIND_W;
    localparam int WORD_W = prps_pkg::WORD_W;
    localparam int PPS_W  = prps_pkg::PPS_W;

    localparam int CYCLE_LIMIT = 1000000;
    // Idle cycles left after the last result before a register write.
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 38;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] pin_word;
        logic              last;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata = '0;   // data_byte[7:0], online_level[8], fault_level[9]
    logic               s_axis_tuser = 1'b0; // opcode[0]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b1;
    logic [WORD_W-1:0]  m_axis_tdata;        // pin_word[31:0]
    logic [KIND_W-1:0]  m_axis_tuser;        // kind[2:0]
    logic               m_axis_tlast;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [PPS_W-1:0]   i_cfg_data = '0;

    // Predictor state: punch mode, the record under way and the stroke limit.
    logic               punch_on = 1'b0;
    logic               rec_open = 1'b0;
    logic [2:0]         rec_count = '0;
    logic [7:0]         rec_bytes [4];
    logic [PPS_W-1:0]   stroke_limit = prps_pkg::PPS_RESET;

    t_result            pending_results[$];
    t_result            item_results[$];
    int                 err_count = 0;
    int                 items_sent = 0;
    int                 results_seen = 0;
    int                 kind_hits [8];
    int                 cycle_count = 0;
    bit                 quiet = 1'b0;

    punch_record_parser_splitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side back-pressure: ready stretches with random stall bursts.
    always begin : sink_pacing
        int hold;
        hold = $urandom_range(1, 40);
        repeat (hold) @(posedge i_clk);
        if (!quiet) begin
            m_axis_tready <= 1'b0;
            hold = $urandom_range(1, 13);
            repeat (hold) @(posedge i_clk);
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            kind_hits[m_axis_tuser]++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d pin_word %h last %0d",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("kind mismatch: expected %0d, actual %0d", want.kind, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata !== want.pin_word) begin
                    $error("pin_word mismatch: expected %h, actual %h",
                           want.pin_word, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last mismatch: expected %0d, actual %0d", want.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    function automatic void stage_result(input logic [KIND_W-1:0] kind,
                                         input logic [WORD_W-1:0] word);
        t_result r;
        r.kind = kind;
        r.pin_word = word;
        r.last = 1'b0;
        item_results.push_back(r);
    endfunction

    function automatic void clear_record();
        rec_open = 1'b0;
        rec_count = '0;
    endfunction

    // Split a pin word into strokes, each closing where the set-pin count reaches
    // the limit; the last one always runs through the paper feed bit.
    function automatic void split_strokes(input logic [WORD_W-1:0] word);
        int unsigned set_pins;
        int unsigned first_bit;
        int unsigned stop_bit;
        int          i;
        int          b;
        logic [WORD_W-1:0] span;
        set_pins = 0;
        first_bit = 0;
        for (i = 0; i <= 30; i++) begin
            if (word[i])
                set_pins++;
            if (set_pins >= stroke_limit || i == 30) begin
                stop_bit = (i == 30) ? 31 : i;
                span = '0;
                for (b = first_bit; b <= stop_bit; b++)
                    span[b] = 1'b1;
                stage_result(prps_pkg::KIND_STROKE, word & span);
                set_pins = 0;
                first_bit = stop_bit + 1;
            end
        end
        stage_result(prps_pkg::KIND_ACK, '0);
    endfunction

    // Work out the results of one accepted request and queue them.
    function automatic void predict_request(input logic op, input logic [7:0] data,
                                            input logic online, input logic fault);
        logic crlf;
        logic all_plus;
        crlf = (data == prps_pkg::BYTE_CR) || (data == prps_pkg::BYTE_LF);
        item_results.delete();
        if (op == prps_pkg::OP_BEGIN) begin
            punch_on = 1'b1;
            clear_record();
            stage_result(prps_pkg::KIND_BEGIN, '0);
        end else if (punch_on && (rec_open || !crlf)) begin
            rec_open = 1'b1;
            if (rec_count < prps_pkg::REC_PIN_BYTES) begin
                rec_bytes[rec_count[1:0]] = data;
                rec_count++;
            end else begin
                all_plus = (rec_bytes[0] == prps_pkg::BYTE_PLUS) &&
                           (rec_bytes[1] == prps_pkg::BYTE_PLUS) &&
                           (rec_bytes[2] == prps_pkg::BYTE_PLUS) &&
                           (rec_bytes[3] == prps_pkg::BYTE_PLUS);
                if (crlf) begin
                    if (!online) begin
                        stage_result(prps_pkg::KIND_OFFLINE, '0);
                        punch_on = 1'b0;
                    end else if (fault) begin
                        stage_result(prps_pkg::KIND_FAULT, '0);
                        punch_on = 1'b0;
                    end else begin
                        split_strokes({rec_bytes[0], rec_bytes[1], rec_bytes[2], rec_bytes[3]});
                    end
                end else if (data == prps_pkg::BYTE_PLUS && all_plus) begin
                    stage_result(prps_pkg::KIND_END, '0);
                    punch_on = 1'b0;
                end else begin
                    stage_result(prps_pkg::KIND_INVALID, '0);
                end
                clear_record();
            end
        end
        if (item_results.size() > 0)
            item_results[item_results.size() - 1].last = 1'b1;
        foreach (item_results[k])
            pending_results.push_back(item_results[k]);
    endfunction

    // Offer one request, wait for it to be taken, then predict its results.
    task automatic send_request(input logic op, input logic [7:0] data,
                                input logic online, input logic fault);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {6'b0, fault, online, data};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        predict_request(op, data, online, fault);
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_request(prps_pkg::OP_DATA, data, 1'($urandom), 1'($urandom));
    endtask

    task automatic send_begin();
        send_request(prps_pkg::OP_BEGIN, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Four pin bytes and a closing byte; the levels only matter on the closing byte.
    task automatic send_record(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [7:0] b3,
                               input logic [7:0] close, input logic online,
                               input logic fault);
        send_byte(b0);
        send_byte(b1);
        send_byte(b2);
        send_byte(b3);
        send_request(prps_pkg::OP_DATA, close, online, fault);
    endtask

    // Stop sending and wait until every predicted result has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_stroke_limit(input logic [PPS_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        stroke_limit = value;
    endtask

    function automatic logic [7:0] pick_pin_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01 << $urandom_range(0, 7);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_non_crlf();
        logic [7:0] b;
        do b = 8'($urandom); while (b == prps_pkg::BYTE_CR || b == prps_pkg::BYTE_LF);
        return b;
    endfunction

    // Bytes outside punch mode are ignored; a begin is acknowledged even when repeated,
    // and line ends before a record are skipped.
    task automatic test_begin_and_idle_bytes();
        send_byte(8'hFF);
        send_byte(prps_pkg::BYTE_PLUS);
        send_begin();
        send_begin();
        send_byte(prps_pkg::BYTE_CR);
        send_byte(prps_pkg::BYTE_LF);
    endtask

    // Full pin word at the reset stroke limit, then line ends inside a record
    // followed by a bad closing byte.
    task automatic test_pin_and_invalid_records();
        send_record(8'hFF, 8'hFF, 8'hFF, 8'hFF, prps_pkg::BYTE_CR, 1'b1, 1'b0);
        send_record(8'h00, prps_pkg::BYTE_CR, prps_pkg::BYTE_LF, 8'h80, 8'h41, 1'b1, 1'b0);
    endtask

    // Fault ends punch mode while online; offline wins over a fault; a plus record ends it.
    task automatic test_record_errors_and_end();
        send_record(8'h81, 8'h00, 8'h00, 8'h01, prps_pkg::BYTE_LF, 1'b1, 1'b1);
        send_begin();
        send_record(8'h12, 8'h34, 8'h56, 8'h78, prps_pkg::BYTE_CR, 1'b0, 1'b1);
        send_begin();
        send_record(prps_pkg::BYTE_PLUS, prps_pkg::BYTE_PLUS, prps_pkg::BYTE_PLUS,
                    prps_pkg::BYTE_PLUS, prps_pkg::BYTE_PLUS, 1'b1, 1'b0);
    endtask

    // One random sequence: mostly well-formed pin records, with end records,
    // broken records, begins in the middle of a record and stray bytes mixed in.
    task automatic send_random_sequence();
        int pick;
        int n;
        int j;
        logic [7:0] close;
        pick = $urandom_range(0, 99);
        if (!punch_on) begin
            if (pick < 20)
                send_byte(8'($urandom));
            else
                send_begin();
        end else if (pick < 70) begin
            if ($urandom_range(0, 3) == 0)
                send_byte($urandom_range(0, 1) ? prps_pkg::BYTE_CR : prps_pkg::BYTE_LF);
            close = $urandom_range(0, 1) ? prps_pkg::BYTE_CR : prps_pkg::BYTE_LF;
            send_record(pick_pin_byte(), pick_pin_byte(), pick_pin_byte(), pick_pin_byte(),
                        close, $urandom_range(0, 15) != 0, $urandom_range(0, 15) == 0);
        end else if (pick < 78) begin
            // End record, sometimes with one byte spoiled.
            n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : 5;
            for (j = 0; j < 5; j++)
                send_byte(j == n ? pick_non_crlf() : prps_pkg::BYTE_PLUS);
        end else if (pick < 88) begin
            send_record(pick_pin_byte(), pick_pin_byte(), pick_pin_byte(), pick_pin_byte(),
                        pick_non_crlf(), 1'($urandom), 1'($urandom));
        end else if (pick < 94) begin
            n = $urandom_range(1, 4);
            for (j = 0; j < n; j++)
                send_byte(pick_pin_byte());
            send_begin();
        end else begin
            send_byte(8'($urandom));
        end
    endtask

    // Random traffic under a series of stroke limits, the extremes among them.
    task automatic test_random_traffic();
        logic [PPS_W-1:0] limits [6];
        int phase_end;
        int p;
        limits = '{5'd1, 5'd31, 5'd0, 5'($urandom_range(2, 30)),
                   5'($urandom_range(2, 30)), prps_pkg::PPS_RESET};
        for (p = 0; p < 6; p++) begin
            write_stroke_limit(limits[p]);
            quiet = (p == 5);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                send_random_sequence();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_begin_and_idle_bytes();
        test_pin_and_invalid_records();
        test_record_errors_and_end();
        test_random_traffic();
        drain_results();
        $display("Sent %0d requests, checked %0d results under stroke limits 0 to 31.",
                 items_sent, results_seen);
        $display("Strokes %0d, acks %0d, ends %0d, invalid %0d, offline %0d, fault %0d, begin %0d.",
                 kind_hits[prps_pkg::KIND_STROKE], kind_hits[prps_pkg::KIND_ACK],
                 kind_hits[prps_pkg::KIND_END], kind_hits[prps_pkg::KIND_INVALID],
                 kind_hits[prps_pkg::KIND_OFFLINE], kind_hits[prps_pkg::KIND_FAULT],
                 kind_hits[prps_pkg::KIND_BEGIN]);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
